@@ hw/rtl/sshdf_pkg.sv @@
// ----------------------------------------------------------------------------
// sshdf_pkg
// shared types and constants for the ssh packet deframer
// ----------------------------------------------------------------------------
package sshdf_pkg;

   // result kinds
   localparam logic [1:0] KindData   = 2'd0;
   localparam logic [1:0] KindDone   = 2'd1;
   localparam logic [1:0] KindLenErr = 2'd2;
   localparam logic [1:0] KindPadErr = 2'd3;

   // configuration register indexes
   localparam logic CsrMaxPacketLen = 1'b0;
   localparam logic CsrMinPadding   = 1'b1;

   // smallest legal packet length field
   localparam logic [31:0] MinPacketLen = 32'd5;

   // configuration reset values
   localparam logic [20:0] MaxPacketLenReset = 21'd35000;
   localparam logic [7:0]  MinPaddingReset   = 8'd4;

   typedef struct packed {
      logic [20:0] max_packet_len;
      logic [7:0]  min_padding;
   } cfg_type;

   typedef struct packed {
      logic        valid;
      logic [1:0]  kind;
      logic [7:0]  payload_byte;
      logic        last_payload;
      logic [31:0] length_field;
      logic [7:0]  pad_field;
      logic [31:0] seq_count;
   } rsp_type;

endpackage

@@ hw/rtl/ssh_packet_deframer_core.sv @@
// ----------------------------------------------------------------------------
// ssh_packet_deframer_core
// receive-side ssh binary packet deframer, one byte per cycle
// ----------------------------------------------------------------------------
// Takes one received byte per word on the req channel and returns at most one
// result word per byte on the rsp channel: a payload byte, a packet-complete
// notice, a length error or a padding error. Throughput is one byte per cycle
// sustained; a byte is held in an input register, goes through a single state
// update step of the framing state machine, and its result lands in an output
// register, from which it is presented on rsp. Bytes that produce no result
// (header, padding length, padding, skipped body) still take one state update
// step each. The input register keeps taking bytes while a result waits in the
// output register, and stalls only when both are full and rsp is held off.
// Configuration (max packet length, min padding) is written through the csr
// channel, which is always ready, and must only change while idle.
// ----------------------------------------------------------------------------
module ssh_packet_deframer_core (
   input  logic        clock,
   input  logic        reset,

   // received byte stream
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_rx_byte,

   // deframed results
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_kind,
   output logic [7:0]  rsp_payload_byte,
   output logic        rsp_last_payload,
   output logic [31:0] rsp_packet_len_out,
   output logic [7:0]  rsp_padding_len_out,
   output logic [31:0] rsp_seq_count,

   // configuration writes
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [20:0] csr_wdata
);

   sshdf_pkg::cfg_type cfg;
   sshdf_pkg::rsp_type step_result;
   sshdf_pkg::rsp_type rsp_ff;

   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic       advance;

   // config registers, writes are always taken
   assign csr_ready = 1'b1;

   sshdf_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // held byte moves through the state machine when the output slot is free or its result is being taken
   assign advance   = in_valid_ff && (!rsp_ff.valid || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_valid && req_ready) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_rx_byte;
      end
   end

   // framing state machine
   sshdf_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .step    (advance),
      .rx_byte (in_byte_ff),
      .cfg     (cfg),
      .result  (step_result)
   );

   // output register, only the valid bit is reset
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_ff.valid <= 1'b0;
      end else if (advance) begin
         rsp_ff.valid <= step_result.valid;
      end else if (rsp_ready) begin
         rsp_ff.valid <= 1'b0;
      end
      if (advance && step_result.valid) begin
         rsp_ff.kind         <= step_result.kind;
         rsp_ff.payload_byte <= step_result.payload_byte;
         rsp_ff.last_payload <= step_result.last_payload;
         rsp_ff.length_field <= step_result.length_field;
         rsp_ff.pad_field    <= step_result.pad_field;
         rsp_ff.seq_count    <= step_result.seq_count;
      end
   end

   assign rsp_valid           = rsp_ff.valid;
   assign rsp_kind            = rsp_ff.kind;
   assign rsp_payload_byte    = rsp_ff.payload_byte;
   assign rsp_last_payload    = rsp_ff.last_payload;
   assign rsp_packet_len_out  = rsp_ff.length_field;
   assign rsp_padding_len_out = rsp_ff.pad_field;
   assign rsp_seq_count       = rsp_ff.seq_count;

   // a held byte that cannot move keeps its value
   a_in_hold: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_byte_ff))
      else $error("held byte lost or changed");

   // a waiting result is never overwritten by a new step
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_ff.valid && !rsp_ready |-> !advance)
      else $error("state stepped while result stalled");

   // only payload words carry data bits
   a_data_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind != sshdf_pkg::KindData)
      |-> (rsp_payload_byte == 8'd0) && !rsp_last_payload)
      else $error("data bits on a non-payload result");

   // payload words carry no lengths
   a_data_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == sshdf_pkg::KindData)
      |-> (rsp_packet_len_out == 32'd0) && (rsp_padding_len_out == 8'd0))
      else $error("lengths on a payload result");

endmodule

@@ hw/rtl/sshdf_csr.sv @@
// ----------------------------------------------------------------------------
// sshdf_csr
// configuration registers of the deframer
// ----------------------------------------------------------------------------
module sshdf_csr (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_valid,
   input  logic             csr_index,
   input  logic [20:0]      csr_wdata,
   output sshdf_pkg::cfg_type cfg
);

   logic [20:0] max_packet_len_ff;
   logic [7:0]  min_padding_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_packet_len_ff <= sshdf_pkg::MaxPacketLenReset;
         min_padding_ff    <= sshdf_pkg::MinPaddingReset;
      end else if (csr_valid) begin
         unique case (csr_index)
            sshdf_pkg::CsrMaxPacketLen: max_packet_len_ff <= csr_wdata;
            sshdf_pkg::CsrMinPadding:   min_padding_ff    <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   assign cfg.max_packet_len = max_packet_len_ff;
   assign cfg.min_padding    = min_padding_ff;

endmodule

@@ hw/rtl/sshdf_parser.sv @@
// ----------------------------------------------------------------------------
// sshdf_parser
// framing state machine: one received byte per step, at most one result
// ----------------------------------------------------------------------------
module sshdf_parser (
   input  logic               clock,
   input  logic               reset,
   input  logic               step,
   input  logic [7:0]         rx_byte,
   input  sshdf_pkg::cfg_type cfg,
   output sshdf_pkg::rsp_type result
);

   typedef enum logic [2:0] {
      PH_LEN,
      PH_PADLEN,
      PH_PAYLOAD,
      PH_PADDING,
      PH_SKIP
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [1:0]  header_index_ff, header_index_in;
   logic [31:0] length_word_ff, length_word_in;
   logic [7:0]  pad_byte_ff, pad_byte_in;
   logic [31:0] bytes_left_ff, bytes_left_in;
   logic [31:0] payload_left_ff, payload_left_in;
   logic [31:0] seq_counter_ff, seq_counter_in;

   logic [31:0] length_shift;
   logic [31:0] payload_rem;
   logic [31:0] rx_wide;
   logic        last_byte;

   assign length_shift = {length_word_ff[23:0], rx_byte};
   assign rx_wide      = {24'd0, rx_byte};
   assign payload_rem  = length_word_ff - 32'd1 - rx_wide;
   assign last_byte    = (payload_left_ff <= 32'd1);

   always_comb begin
      phase_in        = phase_ff;
      header_index_in = header_index_ff;
      length_word_in  = length_word_ff;
      pad_byte_in     = pad_byte_ff;
      bytes_left_in   = bytes_left_ff;
      payload_left_in = payload_left_ff;
      seq_counter_in  = seq_counter_ff;
      result          = '0;

      unique case (phase_ff)
         PH_PADLEN: begin
            pad_byte_in = rx_byte;
            if ((rx_byte < cfg.min_padding) || (rx_wide >= length_word_ff)) begin
               bytes_left_in       = length_word_ff - 32'd1;
               phase_in            = (length_word_ff == 32'd1) ? PH_LEN : PH_SKIP;
               result.valid        = 1'b1;
               result.kind         = sshdf_pkg::KindPadErr;
               result.length_field = length_word_ff;
               result.pad_field    = rx_byte;
            end else begin
               payload_left_in = payload_rem;
               bytes_left_in   = rx_wide;
               phase_in        = (payload_rem != 32'd0) ? PH_PAYLOAD : PH_PADDING;
            end
         end

         PH_PAYLOAD: begin
            payload_left_in = last_byte ? 32'd0 : (payload_left_ff - 32'd1);
            if (last_byte) begin
               if (bytes_left_ff == 32'd0) begin
                  // zero padding: the last payload byte closes the packet
                  seq_counter_in = seq_counter_ff + 32'd1;
                  phase_in       = PH_LEN;
               end else begin
                  phase_in = PH_PADDING;
               end
            end
            result.valid        = 1'b1;
            result.kind         = sshdf_pkg::KindData;
            result.payload_byte = rx_byte;
            result.last_payload = last_byte;
         end

         PH_PADDING: begin
            if (bytes_left_ff <= 32'd1) begin
               bytes_left_in       = 32'd0;
               seq_counter_in      = seq_counter_ff + 32'd1;
               phase_in            = PH_LEN;
               result.valid        = 1'b1;
               result.kind         = sshdf_pkg::KindDone;
               result.length_field = length_word_ff;
               result.pad_field    = pad_byte_ff;
            end else begin
               bytes_left_in = bytes_left_ff - 32'd1;
            end
         end

         PH_SKIP: begin
            if (bytes_left_ff <= 32'd1) begin
               bytes_left_in = 32'd0;
               phase_in      = PH_LEN;
            end else begin
               bytes_left_in = bytes_left_ff - 32'd1;
            end
         end

         default: begin
            // header bytes, big-endian
            length_word_in = length_shift;
            if (header_index_ff != 2'd3) begin
               header_index_in = header_index_ff + 2'd1;
               phase_in        = PH_LEN;
            end else begin
               header_index_in = 2'd0;
               if ((length_shift < sshdf_pkg::MinPacketLen) ||
                   (length_shift > {11'd0, cfg.max_packet_len})) begin
                  phase_in            = PH_LEN;
                  result.valid        = 1'b1;
                  result.kind         = sshdf_pkg::KindLenErr;
                  result.length_field = length_shift;
               end else begin
                  phase_in = PH_PADLEN;
               end
            end
         end
      endcase

      result.seq_count = seq_counter_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_LEN;
         header_index_ff <= 2'd0;
         length_word_ff  <= 32'd0;
         pad_byte_ff     <= 8'd0;
         bytes_left_ff   <= 32'd0;
         payload_left_ff <= 32'd0;
         seq_counter_ff  <= 32'd0;
      end else if (step) begin
         phase_ff        <= phase_in;
         header_index_ff <= header_index_in;
         length_word_ff  <= length_word_in;
         pad_byte_ff     <= pad_byte_in;
         bytes_left_ff   <= bytes_left_in;
         payload_left_ff <= payload_left_in;
         seq_counter_ff  <= seq_counter_in;
      end
   end

   // counter moves only on a step, and then by one at most
   a_seq_hold: assert property (@(posedge clock) disable iff (reset)
      !step |=> $stable(seq_counter_ff))
      else $error("sequence counter moved without a step");

   a_seq_inc: assert property (@(posedge clock) disable iff (reset)
      step |=> (seq_counter_ff == $past(seq_counter_ff)) ||
               (seq_counter_ff == $past(seq_counter_ff) + 32'd1))
      else $error("sequence counter jumped");

   // a completion only ever comes from the padding phase
   a_done_phase: assert property (@(posedge clock) disable iff (reset)
      result.valid && (result.kind == sshdf_pkg::KindDone) |-> phase_ff == PH_PADDING)
      else $error("completion outside padding");

   // header position stays at zero outside the header phase
   a_hdr_idx: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_PAYLOAD) || (phase_ff == PH_PADDING) || (phase_ff == PH_SKIP)
      |-> header_index_ff == 2'd0)
      else $error("header index left over in body");

endmodule
